// File: rtl/mpus_pkg.sv
// shared types and constants for the multiport uart silo service
package mpus_pkg;

    localparam int NUM_PORTS_W = 4;
    localparam logic [NUM_PORTS_W-1:0] NUM_PORTS_RESET = 4'd4;
    localparam logic [3:0] OPEN_MAX = 4'd15;

    localparam logic [2:0] CMD_POLL  = 3'd0;
    localparam logic [2:0] CMD_PUSH  = 3'd1;
    localparam logic [2:0] CMD_POP   = 3'd2;
    localparam logic [2:0] CMD_OPEN  = 3'd3;
    localparam logic [2:0] CMD_CLOSE = 3'd4;

    localparam int MSR_DCTS = 0;
    localparam int MSR_DDSR = 1;
    localparam int MSR_CTS  = 4;
    localparam int MSR_DSR  = 5;

    localparam int LSR_RXRDY = 0;
    localparam int LSR_BRK   = 4;
    localparam int LSR_THRE  = 5;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_POLL,
        OP_PUSH,
        OP_POP,
        OP_OPEN,
        OP_CLOSE
    } op_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [2:0] port;
        logic       modem_mode;
        logic [7:0] modem_status;
        logic [7:0] line_status;
        logic [7:0] rx_byte;
        logic [7:0] tx_byte;
    } in_item_t;

    typedef struct packed {
        logic       accepted;
        logic       send_valid;
        logic [7:0] send_byte;
        logic [7:0] read_byte;
        logic       hangup;
        logic       break_seen;
        logic       carrier;
        logic       stopped;
    } out_item_t;

    typedef struct packed {
        logic carrier;
        logic stopped;
        logic modem_ctrl;
    } flags_t;

    typedef struct packed {
        op_t        op;
        logic       present;
        logic [2:0] port;
        logic       modem_mode;
        logic [7:0] modem_status;
        logic [7:0] line_status;
        logic [7:0] rx_byte;
        logic [7:0] tx_byte;
    } work_t;

endpackage

// File: rtl/multiport_uart_silo_service.sv
// top level of the multiport uart silo service
// Serves up to PORT_COUNT serial ports, each with a receive ring and a transmit
// ring of SILO_DEPTH bytes, through open, close, poll, tx_push and rx_pop
// commands; every input transfer yields exactly one result transfer. A front end
// decodes each command and checks the port against the num_ports register, then
// parks it in a two-entry queue, so input transfers keep flowing until it is
// full while the service engine works or a result waits to be taken. S_FETCH
// reads the per-port indices and issues the ring RAM reads; S_EXEC, which waits
// while a result is not yet taken, updates the port state, writes the rings and
// loads the result register. The num_ports register is written through the cfg
// channel, which is always ready; ring contents need no clearing after reset.
module multiport_uart_silo_service import mpus_pkg::*; #(
    parameter int PORT_COUNT = 8,
    parameter int SILO_DEPTH = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [NUM_PORTS_W-1:0] cfg_data
);

    logic  fq_valid;
    logic  fq_ready;
    work_t fq_data;
    logic  qb_valid;
    logic  qb_ready;
    work_t qb_data;

    mpus_front #(
        .PORT_COUNT (PORT_COUNT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_data    (fq_data)
    );

    mpus_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    mpus_back #(
        .PORT_COUNT (PORT_COUNT),
        .SILO_DEPTH (SILO_DEPTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: rtl/mpus_front.sv
// front end: takes input transfers, holds the port count register, decodes commands
module mpus_front import mpus_pkg::*; #(
    parameter int PORT_COUNT = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [NUM_PORTS_W-1:0] cfg_data,
    output logic                   q_valid,
    input  logic                   q_ready,
    output work_t                  q_data
);

    logic [NUM_PORTS_W-1:0] num_ports_reg;
    op_t                    op;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_ports_reg <= NUM_PORTS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            num_ports_reg <= cfg_data;
        end
    end

    always_comb begin
        unique case (s_data.cmd)
            CMD_POLL:  op = OP_POLL;
            CMD_PUSH:  op = OP_PUSH;
            CMD_POP:   op = OP_POP;
            CMD_OPEN:  op = OP_OPEN;
            CMD_CLOSE: op = OP_CLOSE;
            default:   op = OP_NONE;
        endcase
    end

    assign cfg_ready = 1'b1;
    assign s_ready   = q_ready;
    assign q_valid   = s_valid;

    always_comb begin
        q_data.op           = op;
        q_data.present      = ({1'b0, s_data.port} < num_ports_reg)
                              && (int'(s_data.port) < PORT_COUNT);
        q_data.port         = s_data.port;
        q_data.modem_mode   = s_data.modem_mode;
        q_data.modem_status = s_data.modem_status;
        q_data.line_status  = s_data.line_status;
        q_data.rx_byte      = s_data.rx_byte;
        q_data.tx_byte      = s_data.tx_byte;
    end

endmodule

// File: rtl/mpus_queue.sv
// two-entry queue between the front end and the service engine
module mpus_queue import mpus_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  work_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output work_t out_data
);

    work_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// File: rtl/mpus_back.sv
// service engine: per-port state, receive and transmit rings, result register
module mpus_back import mpus_pkg::*; #(
    parameter int PORT_COUNT = 8,
    parameter int SILO_DEPTH = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    output logic      q_ready,
    input  work_t     q_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int PW        = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int IW        = $clog2(SILO_DEPTH);
    localparam int AW        = PW + IW;
    localparam int MEM_DEPTH = PORT_COUNT * (2 ** IW);
    localparam logic [IW-1:0] LAST_SLOT = IW'(SILO_DEPTH - 1);

    typedef logic [IW-1:0] slot_t;
    typedef enum logic {S_FETCH, S_EXEC} state_t;

    function automatic slot_t next_slot(slot_t i);
        return (i == LAST_SLOT) ? '0 : i + 1'b1;
    endfunction

    state_t     state_reg;
    work_t      work_reg;
    logic       m_valid_reg;
    out_item_t  m_data_reg;
    logic [7:0] rx_rdata_reg;
    logic [7:0] tx_rdata_reg;

    logic [3:0] open_cnt_reg [PORT_COUNT];
    flags_t     flags_reg    [PORT_COUNT];
    slot_t      rx_wr_reg    [PORT_COUNT];
    slot_t      rx_rd_reg    [PORT_COUNT];
    slot_t      tx_wr_reg    [PORT_COUNT];
    slot_t      tx_rd_reg    [PORT_COUNT];

    logic [7:0] rx_mem [MEM_DEPTH];
    logic [7:0] tx_mem [MEM_DEPTH];

    logic [PW-1:0] fetch_pi;
    logic [PW-1:0] exec_pi;
    logic          exec_go;

    logic [3:0] cnt;
    flags_t     f;
    slot_t      rx_w;
    slot_t      rx_r;
    slot_t      tx_w;
    slot_t      tx_r;
    slot_t      tx_nw;
    logic       is_open;
    logic [3:0] cnt_next;
    flags_t     f_next;
    slot_t      rx_w_next;
    slot_t      rx_r_next;
    slot_t      tx_w_next;
    slot_t      tx_r_next;
    logic       rx_we;
    logic       tx_we;
    out_item_t  res;

    assign fetch_pi = PW'(q_data.port);
    assign exec_pi  = PW'(work_reg.port);
    assign exec_go  = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);
    assign q_ready  = (state_reg == S_FETCH);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // ring reads issued while the item is taken from the queue
    always_ff @(posedge aclk) begin
        if (state_reg == S_FETCH) begin
            rx_rdata_reg <= rx_mem[AW'({fetch_pi, rx_rd_reg[fetch_pi]})];
            tx_rdata_reg <= tx_mem[AW'({fetch_pi, tx_rd_reg[fetch_pi]})];
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_go && rx_we) begin
            rx_mem[AW'({exec_pi, rx_w})] <= work_reg.rx_byte;
        end
        if (exec_go && tx_we) begin
            tx_mem[AW'({exec_pi, tx_w})] <= work_reg.tx_byte;
        end
    end

    always_comb begin
        cnt       = open_cnt_reg[exec_pi];
        f         = flags_reg[exec_pi];
        rx_w      = rx_wr_reg[exec_pi];
        rx_r      = rx_rd_reg[exec_pi];
        tx_w      = tx_wr_reg[exec_pi];
        tx_r      = tx_rd_reg[exec_pi];
        tx_nw     = next_slot(tx_w);
        is_open   = (cnt != 4'd0);
        cnt_next  = cnt;
        f_next    = f;
        rx_w_next = rx_w;
        rx_r_next = rx_r;
        tx_w_next = tx_w;
        tx_r_next = tx_r;
        rx_we     = 1'b0;
        tx_we     = 1'b0;
        res       = '0;
        if (work_reg.present) begin
            unique case (work_reg.op)
                OP_POLL: begin
                    if (is_open) begin
                        if (f.modem_ctrl) begin
                            if (work_reg.modem_status[MSR_DCTS]) begin
                                f_next.stopped = !work_reg.modem_status[MSR_CTS];
                            end
                            if (work_reg.modem_status[MSR_DDSR]) begin
                                f_next.carrier = work_reg.modem_status[MSR_DSR];
                                res.hangup     = !work_reg.modem_status[MSR_DSR];
                            end
                        end
                        res.break_seen = work_reg.line_status[LSR_BRK] && f_next.carrier;
                        if (work_reg.line_status[LSR_RXRDY]) begin
                            rx_we = 1'b1;
                            if (f_next.carrier) begin
                                rx_w_next = next_slot(rx_w);
                            end
                        end
                        if (work_reg.line_status[LSR_THRE] && !f_next.stopped
                            && (tx_w != tx_r)) begin
                            res.send_valid = 1'b1;
                            res.send_byte  = tx_rdata_reg;
                            tx_r_next      = next_slot(tx_r);
                        end
                        res.accepted = 1'b1;
                    end
                end
                OP_PUSH: begin
                    if (is_open && (tx_nw != tx_r)) begin
                        tx_we        = 1'b1;
                        tx_w_next    = tx_nw;
                        res.accepted = 1'b1;
                    end
                end
                OP_POP: begin
                    if (is_open && (rx_w != rx_r)) begin
                        res.read_byte = rx_rdata_reg;
                        rx_r_next     = next_slot(rx_r);
                        res.accepted  = 1'b1;
                    end
                end
                OP_OPEN: begin
                    if (cnt < OPEN_MAX) begin
                        cnt_next = cnt + 4'd1;
                        if (!is_open) begin
                            if (work_reg.modem_mode) begin
                                f_next.modem_ctrl = 1'b1;
                                f_next.stopped    = !work_reg.modem_status[MSR_CTS];
                                f_next.carrier    = work_reg.modem_status[MSR_DSR];
                            end else begin
                                f_next.modem_ctrl = 1'b0;
                                f_next.stopped    = 1'b0;
                                f_next.carrier    = 1'b1;
                            end
                        end
                        res.accepted = 1'b1;
                    end
                end
                OP_CLOSE: begin
                    if (is_open) begin
                        cnt_next = cnt - 4'd1;
                        if (cnt == 4'd1) begin
                            f_next    = '0;
                            rx_w_next = '0;
                            rx_r_next = '0;
                            tx_w_next = '0;
                            tx_r_next = '0;
                        end
                        res.accepted = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            res.carrier = f_next.carrier;
            res.stopped = f_next.stopped;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_FETCH;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < PORT_COUNT; i++) begin
                open_cnt_reg[i] <= '0;
                flags_reg[i]    <= '0;
                rx_wr_reg[i]    <= '0;
                rx_rd_reg[i]    <= '0;
                tx_wr_reg[i]    <= '0;
                tx_rd_reg[i]    <= '0;
            end
        end else begin
            if (exec_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_FETCH: begin
                    if (q_valid) begin
                        work_reg  <= q_data;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec_go) begin
                        m_data_reg <= res;
                        state_reg  <= S_FETCH;
                        if (work_reg.present) begin
                            open_cnt_reg[exec_pi] <= cnt_next;
                            flags_reg[exec_pi]    <= f_next;
                            rx_wr_reg[exec_pi]    <= rx_w_next;
                            rx_rd_reg[exec_pi]    <= rx_r_next;
                            tx_wr_reg[exec_pi]    <= tx_w_next;
                            tx_rd_reg[exec_pi]    <= tx_r_next;
                        end
                    end
                end
                default: begin
                    state_reg <= S_FETCH;
                end
            endcase
        end
    end

endmodule
